### design/rlh_pkg.sv
// Shared types and constants for the request latency histogram.
// Holds operation codes, counter read indexes, bucket bounds and the update struct.
// No dependencies.
`default_nettype none

package rlh_pkg;

  localparam int OP_W      = 2;
  localparam int STATUS_W  = 10;
  localparam int LATENCY_W = 32;
  localparam int INDEX_W   = 5;
  localparam int READ_W    = 64;

  localparam int NUM_BUCKETS           = 12;
  localparam int BUCKET_IDX_W          = $clog2(NUM_BUCKETS);
  localparam int DEFAULT_COUNTER_WIDTH = 64;

  // Operation codes
  localparam logic [OP_W-1:0] OP_RECORD = 2'd0;
  localparam logic [OP_W-1:0] OP_LOGIN  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  // Counter read indexes
  localparam logic [INDEX_W-1:0] IDX_REQUESTS     = 5'd0;
  localparam logic [INDEX_W-1:0] IDX_OK           = 5'd1;
  localparam logic [INDEX_W-1:0] IDX_CLIENT_ERR   = 5'd2;
  localparam logic [INDEX_W-1:0] IDX_SERVER_ERR   = 5'd3;
  localparam logic [INDEX_W-1:0] IDX_BUSY         = 5'd4;
  localparam logic [INDEX_W-1:0] IDX_LOGINS       = 5'd5;
  localparam logic [INDEX_W-1:0] IDX_SAMPLES      = 5'd6;
  localparam logic [INDEX_W-1:0] IDX_SUM          = 5'd7;
  localparam logic [INDEX_W-1:0] IDX_PEAK         = 5'd8;
  localparam logic [INDEX_W-1:0] IDX_BUCKET_FIRST = 5'd9;
  localparam logic [INDEX_W-1:0] IDX_BUCKET_LAST  = INDEX_W'(9 + NUM_BUCKETS - 1);

  // Status code class limits
  localparam logic [STATUS_W-1:0] STATUS_OK_LO     = 10'd200;
  localparam logic [STATUS_W-1:0] STATUS_OK_HI     = 10'd300;
  localparam logic [STATUS_W-1:0] STATUS_CLIENT_LO = 10'd400;
  localparam logic [STATUS_W-1:0] STATUS_SERVER_LO = 10'd500;
  localparam logic [STATUS_W-1:0] STATUS_BUSY      = 10'd503;

  // Inclusive upper bounds of the fixed buckets, in microseconds (1 ms .. 2000 ms)
  localparam logic [LATENCY_W-1:0] BUCKET_BOUND_US [NUM_BUCKETS-1] = '{
    32'd1000,   32'd2000,   32'd5000,   32'd10000,  32'd20000, 32'd50000,
    32'd100000, 32'd200000, 32'd500000, 32'd1000000, 32'd2000000
  };

  // One decoded event for the counter bank
  typedef struct packed {
    logic                    record;
    logic                    login;
    logic                    ok;
    logic                    client_err;
    logic                    server_err;
    logic                    busy;
    logic [BUCKET_IDX_W-1:0] bucket;
    logic [LATENCY_W-1:0]    latency;
  } rlh_update_t;

endpackage

`default_nettype wire

### design/request_latency_histogram.sv
// Top level of the request latency histogram counter bank.
// Depends on rlh_pkg, rlh_classify and rlh_counters.
//
// Usage:
//   Events arrive on the s_axis channel. tuser carries the operation
//   (record request, count login, read counter); tdata carries the status
//   code, latency in microseconds and the counter index to read.
//   Only read events produce a transfer on m_axis: the 64-bit counter value,
//   zero-extended from COUNTER_WIDTH (or from 32 bits for the latency peak).
//   Unknown indexes read as zero; operation code 3 is dropped silently.
// Pipeline: an event is captured in the input register, then decoded and applied
//   to the counters (or used to load the output register) as it leaves that register;
//   a read result passes through the input and output registers to m_axis.
//   A read always sees every event accepted before it.
// Throughput: one event per cycle sustained while no read waits on a held-off
//   output register. Bucket compares, the status decode and the 64-bit
//   increments all fit between the input register and the counter/output registers.
// Reset: rst clears every counter, the latency peak, and both valid flags.
// Stall: while m_axis is held off with a result pending, record and login
//   events keep flowing; only a read waiting in the input register blocks,
//   which then drops s_axis_tready until the output register drains.
`default_nettype none

module request_latency_histogram import rlh_pkg::*; #(
  parameter int COUNTER_WIDTH = DEFAULT_COUNTER_WIDTH
) (
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // [9:0] status_code, [41:10] latency_us,
                                           // [46:42] counter_index, [47] zero
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] operation

  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata    // [63:0] counter_value
);

  // input register
  logic                 stage_valid;
  logic [OP_W-1:0]      stage_op;
  logic [STATUS_W-1:0]  stage_status;
  logic [LATENCY_W-1:0] stage_latency;
  logic [INDEX_W-1:0]   stage_index;

  // output register
  logic                 out_valid;
  logic [READ_W-1:0]    out_data;

  logic                 stage_advance;
  logic                 in_load;
  logic                 stage_is_read;
  rlh_update_t          update;
  logic [READ_W-1:0]    read_value;

  assign stage_is_read = (stage_op == OP_READ);

  // a read can only leave the input register if the output register has room
  assign stage_advance = stage_valid && (!stage_is_read || !out_valid || m_axis_tready);
  assign s_axis_tready = !stage_valid || stage_advance;
  assign in_load       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_load) begin
      stage_valid <= 1'b1;
    end else if (stage_advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      stage_op      <= s_axis_tuser;
      stage_status  <= s_axis_tdata[9:0];
      stage_latency <= s_axis_tdata[41:10];
      stage_index   <= s_axis_tdata[46:42];
    end
  end

  rlh_classify u_classify (
    .fire        (stage_advance),
    .operation   (stage_op),
    .status_code (stage_status),
    .latency_us  (stage_latency),
    .update      (update)
  );

  rlh_counters #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_counters (
    .clk        (clk),
    .rst        (rst),
    .update     (update),
    .read_index (stage_index),
    .read_value (read_value)
  );

  // result register: loads on a read leaving the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_advance && stage_is_read) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_advance && stage_is_read) begin
      out_data <= read_value;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  a_read_waits_for_room: assert property (@(posedge clk) disable iff (rst)
    stage_valid && stage_is_read && out_valid && !m_axis_tready |=> stage_valid)
    else $error("read left input register while result was blocked");

  a_result_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(stage_valid && stage_is_read))
    else $error("result produced without a read event");

  a_ready_low_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> stage_valid && stage_is_read && out_valid)
    else $error("input stalled without a blocked read");

endmodule

`default_nettype wire

### design/rlh_classify.sv
// Event decoder: status class and latency bucket for one recorded request.
// Depends on rlh_pkg.
`default_nettype none

module rlh_classify import rlh_pkg::*; (
  input  wire logic                 fire,
  input  wire logic [OP_W-1:0]      operation,
  input  wire logic [STATUS_W-1:0]  status_code,
  input  wire logic [LATENCY_W-1:0] latency_us,
  output rlh_update_t               update
);

  logic [NUM_BUCKETS-2:0]  within_bound;
  logic [BUCKET_IDX_W-1:0] bucket;

  // bounds ascend, so the lowest matching bound wins; none matching is overflow
  always_comb begin
    bucket = BUCKET_IDX_W'(NUM_BUCKETS - 1);
    for (int i = NUM_BUCKETS - 2; i >= 0; i--) begin
      within_bound[i] = (latency_us <= BUCKET_BOUND_US[i]);
      if (within_bound[i]) begin
        bucket = BUCKET_IDX_W'(i);
      end
    end
  end

  always_comb begin
    update.record     = fire && (operation == OP_RECORD);
    update.login      = fire && (operation == OP_LOGIN);
    update.ok         = (status_code >= STATUS_OK_LO) && (status_code < STATUS_OK_HI);
    update.client_err = (status_code >= STATUS_CLIENT_LO) && (status_code < STATUS_SERVER_LO);
    update.server_err = (status_code >= STATUS_SERVER_LO);
    update.busy       = (status_code == STATUS_BUSY);
    update.bucket     = bucket;
    update.latency    = latency_us;
  end

endmodule

`default_nettype wire

### design/rlh_counters.sv
// Counter bank: request/status/login counters, latency sum and peak, bucket counts,
// plus the read select. Depends on rlh_pkg.
`default_nettype none

module rlh_counters import rlh_pkg::*; #(
  parameter int COUNTER_WIDTH = DEFAULT_COUNTER_WIDTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire rlh_update_t        update,
  input  wire logic [INDEX_W-1:0] read_index,
  output logic      [READ_W-1:0]  read_value
);

  localparam logic [COUNTER_WIDTH-1:0] ONE = COUNTER_WIDTH'(1);

  logic [COUNTER_WIDTH-1:0] request_total;
  logic [COUNTER_WIDTH-1:0] success_count;
  logic [COUNTER_WIDTH-1:0] client_error_count;
  logic [COUNTER_WIDTH-1:0] server_error_count;
  logic [COUNTER_WIDTH-1:0] busy_count;
  logic [COUNTER_WIDTH-1:0] login_count;
  logic [COUNTER_WIDTH-1:0] latency_samples;
  logic [COUNTER_WIDTH-1:0] latency_sum;
  logic [LATENCY_W-1:0]     latency_peak;
  logic [COUNTER_WIDTH-1:0] bucket_counts [NUM_BUCKETS];

  logic [BUCKET_IDX_W-1:0]  bucket_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      request_total      <= '0;
      success_count      <= '0;
      client_error_count <= '0;
      server_error_count <= '0;
      busy_count         <= '0;
      login_count        <= '0;
      latency_samples    <= '0;
      latency_sum        <= '0;
      latency_peak       <= '0;
      for (int b = 0; b < NUM_BUCKETS; b++) begin
        bucket_counts[b] <= '0;
      end
    end else begin
      if (update.record) begin
        request_total   <= request_total + ONE;
        latency_samples <= latency_samples + ONE;
        latency_sum     <= latency_sum + COUNTER_WIDTH'(update.latency);
        if (update.ok) begin
          success_count <= success_count + ONE;
        end else if (update.client_err) begin
          client_error_count <= client_error_count + ONE;
        end else if (update.server_err) begin
          server_error_count <= server_error_count + ONE;
        end
        if (update.busy) begin
          busy_count <= busy_count + ONE;
        end
        if (update.latency > latency_peak) begin
          latency_peak <= update.latency;
        end
        for (int b = 0; b < NUM_BUCKETS; b++) begin
          if (update.bucket == BUCKET_IDX_W'(b)) begin
            bucket_counts[b] <= bucket_counts[b] + ONE;
          end
        end
      end
      if (update.login) begin
        login_count <= login_count + ONE;
      end
    end
  end

  assign bucket_sel = BUCKET_IDX_W'(read_index - IDX_BUCKET_FIRST);

  always_comb begin
    unique case (read_index) inside
      IDX_REQUESTS:   read_value = READ_W'(request_total);
      IDX_OK:         read_value = READ_W'(success_count);
      IDX_CLIENT_ERR: read_value = READ_W'(client_error_count);
      IDX_SERVER_ERR: read_value = READ_W'(server_error_count);
      IDX_BUSY:       read_value = READ_W'(busy_count);
      IDX_LOGINS:     read_value = READ_W'(login_count);
      IDX_SAMPLES:    read_value = READ_W'(latency_samples);
      IDX_SUM:        read_value = READ_W'(latency_sum);
      IDX_PEAK:       read_value = READ_W'(latency_peak);
      [IDX_BUCKET_FIRST:IDX_BUCKET_LAST]: read_value = READ_W'(bucket_counts[bucket_sel]);
      default:        read_value = '0;
    endcase
  end

  // every record bumps both, so they move in lockstep
  a_samples_track_requests: assert property (@(posedge clk) disable iff (rst)
    request_total == latency_samples)
    else $error("latency sample count diverged from request count");

  a_peak_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> latency_peak >= $past(latency_peak))
    else $error("latency peak decreased");

  a_busy_with_server: assert property (@(posedge clk) disable iff (rst)
    update.record && update.busy |=> server_error_count == $past(server_error_count) + ONE)
    else $error("503 not counted as a 5xx");

endmodule

`default_nettype wire

### verif/tb_request_latency_histogram.sv
// Self-checking testbench for request_latency_histogram: directed and random event streams.
// Predicts every counter read in-bench and scores it against m_axis in transfer order.
// Depends on rlh_pkg and the request_latency_histogram RTL.
`default_nettype none

module tb_request_latency_histogram;
  import rlh_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF_NS = 4;
  localparam int RUN_LIMIT   = 400000;   // cycles
  localparam int ITEMS_PER_PHASE = 330;

  // Operation code with no function in the block; it must be swallowed silently.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Status class thresholds
  localparam logic [STATUS_W-1:0] CODE_OK_FIRST     = 10'd200;
  localparam logic [STATUS_W-1:0] CODE_OK_END       = 10'd300;
  localparam logic [STATUS_W-1:0] CODE_CLIENT_FIRST = 10'd400;
  localparam logic [STATUS_W-1:0] CODE_SERVER_FIRST = 10'd500;
  localparam logic [STATUS_W-1:0] CODE_BUSY         = 10'd503;

  // Inclusive bucket bounds in microseconds; anything above the last goes to overflow.
  localparam int NUM_BOUNDS = NUM_BUCKETS - 1;
  localparam logic [31:0] latency_bound_us [NUM_BOUNDS] = '{
    32'd1000, 32'd2000, 32'd5000, 32'd10000, 32'd20000, 32'd50000,
    32'd100000, 32'd200000, 32'd500000, 32'd1000000, 32'd2000000
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // [9:0] status_code, [41:10] latency_us,
                                    // [46:42] counter_index, [47] zero
  logic [1:0]  s_axis_tuser = '0;   // [1:0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // [63:0] counter_value

  // Idle percentages per phase, changed only by the test sequence
  int unsigned send_idle_pct = 17;
  int unsigned recv_stall_pct = 64;

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // Shadow copy of the counter bank
  logic [63:0] requests_seen;
  logic [63:0] ok_seen;
  logic [63:0] client_err_seen;
  logic [63:0] server_err_seen;
  logic [63:0] busy_seen;
  logic [63:0] logins_seen;
  logic [63:0] samples_seen;
  logic [63:0] latency_total;
  logic [31:0] latency_max;
  logic [63:0] bucket_hits [NUM_BUCKETS];

  // Counter values owed by the block, oldest read first
  logic [63:0] owed_reads_q [$];

  request_latency_histogram dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #(CLK_HALF_NS) clk = ~clk;

  // Watchdog: a hung handshake or a result that never shows ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: random backpressure on the result side.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] counter_at(input logic [INDEX_W-1:0] idx);
    case (idx)
      IDX_REQUESTS:   return requests_seen;
      IDX_OK:         return ok_seen;
      IDX_CLIENT_ERR: return client_err_seen;
      IDX_SERVER_ERR: return server_err_seen;
      IDX_BUSY:       return busy_seen;
      IDX_LOGINS:     return logins_seen;
      IDX_SAMPLES:    return samples_seen;
      IDX_SUM:        return latency_total;
      IDX_PEAK:       return {32'd0, latency_max};
      default: begin
        if (idx >= IDX_BUCKET_FIRST && idx <= IDX_BUCKET_LAST)
          return bucket_hits[idx - IDX_BUCKET_FIRST];
        return 64'd0;   // indexes past the last bucket read as zero
      end
    endcase
  endfunction

  // Applies one accepted event to the shadow bank; reads queue their expected value.
  task automatic tally_event(input logic [OP_W-1:0] op, input logic [STATUS_W-1:0] status,
                             input logic [31:0] lat, input logic [INDEX_W-1:0] idx);
    int unsigned slot;
    slot = NUM_BUCKETS - 1;
    case (op)
      OP_RECORD: begin
        requests_seen = requests_seen + 1;
        if (status >= CODE_OK_FIRST && status < CODE_OK_END)
          ok_seen = ok_seen + 1;
        else if (status >= CODE_CLIENT_FIRST && status < CODE_SERVER_FIRST)
          client_err_seen = client_err_seen + 1;
        else if (status >= CODE_SERVER_FIRST)
          server_err_seen = server_err_seen + 1;
        if (status == CODE_BUSY)
          busy_seen = busy_seen + 1;
        samples_seen  = samples_seen + 1;
        latency_total = latency_total + {32'd0, lat};
        if (lat > latency_max)
          latency_max = lat;
        // walk down so the lowest bound that still holds wins
        for (int b = NUM_BOUNDS - 1; b >= 0; b--) begin
          if (lat <= latency_bound_us[b])
            slot = b;
        end
        bucket_hits[slot] = bucket_hits[slot] + 1;
      end
      OP_LOGIN: logins_seen = logins_seen + 1;
      OP_READ:  owed_reads_q.push_back(counter_at(idx));
      default: ;
    endcase
  endtask

  // Input monitor: every transfer in goes through the predictor in acceptance order.
  always @(posedge clk) begin
    if (rst) begin
      requests_seen   = '0;
      ok_seen         = '0;
      client_err_seen = '0;
      server_err_seen = '0;
      busy_seen       = '0;
      logins_seen     = '0;
      samples_seen    = '0;
      latency_total   = '0;
      latency_max     = '0;
      for (int i = 0; i < NUM_BUCKETS; i++)
        bucket_hits[i] = '0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      tally_event(s_axis_tuser, s_axis_tdata[9:0], s_axis_tdata[41:10], s_axis_tdata[46:42]);
    end
  end

  // Result checker: each transfer out is matched against the oldest owed read.
  always @(posedge clk) begin : score_reads
    logic [63:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (owed_reads_q.size() == 0) begin
        $display("%0t: unexpected counter_value transfer: expected none, actual 0x%016h",
                 $time, m_axis_tdata);
        error_count++;
      end else begin
        want = owed_reads_q.pop_front();
        if (m_axis_tdata !== want) begin
          $display("%0t: counter_value mismatch: expected 0x%016h, actual 0x%016h",
                   $time, want, m_axis_tdata);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Drives one event and returns at the edge that takes it. tvalid stays high on
  // return so back-to-back calls stream without a bubble.
  task automatic send_event(input logic [OP_W-1:0] op, input logic [STATUS_W-1:0] status,
                            input logic [31:0] lat, input logic [INDEX_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, idx, lat, status};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic record_event(input logic [STATUS_W-1:0] status, input logic [31:0] lat);
    send_event(OP_RECORD, status, lat, INDEX_W'($urandom()));
  endtask

  task automatic read_event(input logic [INDEX_W-1:0] idx);
    send_event(OP_READ, STATUS_W'($urandom()), $urandom(), idx);
  endtask

  // Every class boundary of the status decode, with latencies on the bucket edges.
  task automatic test_status_classes();
    record_event(10'd0,    32'd0);
    record_event(10'd199,  32'd1000);
    record_event(10'd200,  32'd1001);
    record_event(10'd299,  32'd2000000);
    record_event(10'd300,  32'd2000001);
    record_event(10'd399,  32'hFFFF_FFFF);
    record_event(10'd400,  32'd1);
    record_event(10'd499,  32'd5000);
    record_event(10'd500,  32'd50001);
    record_event(CODE_BUSY, 32'd999999);
    record_event(10'd1023, 32'd1999);
    read_event(IDX_REQUESTS);
    read_event(IDX_SERVER_ERR);
    read_event(IDX_BUSY);
  endtask

  // Logins count on their own; the unused operation must leave no trace.
  task automatic test_logins_and_drops();
    send_event(OP_LOGIN, '1, '1, '1);
    send_event(OP_UNUSED, CODE_OK_FIRST, 32'd10, IDX_LOGINS);
    send_event(OP_LOGIN, '0, '0, '0);
    read_event(IDX_LOGINS);
  endtask

  // Latency aggregates, first and last buckets, and indexes past the bank.
  task automatic test_latency_readback();
    read_event(IDX_SAMPLES);
    read_event(IDX_SUM);
    read_event(IDX_PEAK);
    read_event(IDX_BUCKET_FIRST);
    read_event(IDX_BUCKET_LAST);
    read_event(INDEX_W'(IDX_BUCKET_LAST + 1));
    read_event('1);
  endtask

  function automatic logic [31:0] pick_latency();
    int unsigned b;
    b = $urandom_range(NUM_BOUNDS - 1);
    case ($urandom_range(9))
      0, 1:    return latency_bound_us[b];
      2:       return latency_bound_us[b] + 1;
      3:       return latency_bound_us[b] - 1;
      4:       return $urandom();
      5:       return $urandom_range(2000);
      default: return $urandom_range(2500000);
    endcase
  endfunction

  function automatic logic [STATUS_W-1:0] pick_status();
    case ($urandom_range(7))
      0:       return CODE_BUSY;
      1:       return STATUS_W'($urandom_range(CODE_OK_END - 1, CODE_OK_FIRST));
      2:       return STATUS_W'($urandom_range(CODE_SERVER_FIRST - 1, CODE_CLIENT_FIRST));
      3:       return STATUS_W'($urandom_range(1023, CODE_SERVER_FIRST));
      default: return STATUS_W'($urandom());
    endcase
  endfunction

  // Mixed traffic; dropped operations do not count toward the item total.
  task automatic test_random_traffic(input int unsigned items);
    int unsigned sent;
    int unsigned pick;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        record_event(pick_status(), pick_latency());
        sent++;
      end else if (pick < 60) begin
        send_event(OP_LOGIN, STATUS_W'($urandom()), $urandom(), INDEX_W'($urandom()));
        sent++;
      end else if (pick < 96) begin
        if ($urandom_range(99) < 85)
          read_event(INDEX_W'($urandom_range(IDX_BUCKET_LAST)));
        else
          read_event(INDEX_W'($urandom_range(31, IDX_BUCKET_LAST + 1)));
        sent++;
      end else begin
        send_event(OP_UNUSED, STATUS_W'($urandom()), $urandom(), INDEX_W'($urandom()));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // sender mostly busy, receiver heavily stalled
    send_idle_pct  = 17;
    recv_stall_pct = 64;
    test_status_classes();
    test_logins_and_drops();
    test_latency_readback();
    test_random_traffic(ITEMS_PER_PHASE);

    // sender starved, receiver mostly ready
    send_idle_pct  = 64;
    recv_stall_pct = 17;
    test_random_traffic(ITEMS_PER_PHASE);

    // full rate both ways
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(ITEMS_PER_PHASE);

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (owed_reads_q.size() != 0)
      @(posedge clk);
    // pipeline is two deep; keep waiting so any stray transfer shows
    repeat (8) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
design/rlh_pkg.sv
design/rlh_classify.sv
design/rlh_counters.sv
design/request_latency_histogram.sv
verif/tb_request_latency_histogram.sv
